// ----- hw/rtl/lrfc_pkg.sv -----
// lrfc_pkg: types, constants and register indexes for the lidar ring feature classifier.
// No dependencies.
package lrfc_pkg;
    localparam int HALF_WINDOW_DEF = 5;
    localparam int COORD_BITS = 20;
    localparam int DIFF_BITS = 26;   // |D| <= 32*2^19 for HALF_WINDOW up to 8
    localparam int NUM_BITS = 62;
    localparam int DEN_BITS = 42;
    localparam int CFG_ADDR_BITS = 3;
    localparam int CFG_DATA_BITS = 24;
    localparam logic [23:0] SAT24 = 24'hFFFFFF;
    localparam logic [17:0] GRAD_SCALE = 18'd256000;

    localparam logic [CFG_ADDR_BITS-1:0] REG_EDGE_THR   = 3'd0;
    localparam logic [CFG_ADDR_BITS-1:0] REG_PLANAR_THR = 3'd1;
    localparam logic [CFG_ADDR_BITS-1:0] REG_GRAD_MIN   = 3'd2;
    localparam logic [CFG_ADDR_BITS-1:0] REG_GRAD_MAX   = 3'd3;
    localparam logic [CFG_ADDR_BITS-1:0] REG_PPR        = 3'd4;
    localparam logic [CFG_ADDR_BITS-1:0] REG_RING_CNT   = 3'd5;
    localparam logic [CFG_ADDR_BITS-1:0] REG_INT_EN     = 3'd6;

    localparam logic [1:0] PC_NONE      = 2'd0;
    localparam logic [1:0] PC_EDGE      = 2'd1;
    localparam logic [1:0] PC_PLANAR    = 2'd2;
    localparam logic [1:0] PC_INTENSITY = 2'd3;

    typedef struct packed {
        logic signed [19:0] pos_x;
        logic signed [19:0] pos_y;
        logic signed [19:0] pos_z;
        logic [7:0]         reflectivity;
        logic               scan_start;
    } t_point;

    typedef struct packed {
        logic signed [19:0] out_x;
        logic signed [19:0] out_y;
        logic signed [19:0] out_z;
        logic [7:0]         out_reflectivity;
        logic [6:0]         ring_index;
        logic [1:0]         point_class;
        logic [23:0]        smoothness_value;
        logic [23:0]        gradient_value;
    } t_result;

    typedef struct packed {
        logic [23:0] edge_limit;
        logic [23:0] flat_limit;
        logic [23:0] gradient_min;
        logic [23:0] gradient_max;
        logic [15:0] points_per_ring;
        logic [7:0]  ring_count;
        logic        intensity_enable;
    } t_cfg;

    // One centre point handed from front to back.
    typedef struct packed {
        logic signed [19:0]           cx;
        logic signed [19:0]           cy;
        logic signed [19:0]           cz;
        logic [7:0]                   refl;
        logic [6:0]                   ring;
        logic signed [DIFF_BITS-1:0] dx;
        logic signed [DIFF_BITS-1:0] dy;
        logic signed [DIFF_BITS-1:0] dz;
        logic [7:0]                   grad_in;
    } t_job;
endpackage

// ----- hw/rtl/lrfc_front.sv -----
// lrfc_front: sliding point window, ring/position counters, neighbor differences.
// Depends on lrfc_pkg.
module lrfc_front import lrfc_pkg::*; #(
    parameter int HALF_WINDOW = HALF_WINDOW_DEF
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_take,
    input  t_point i_pt,
    input  t_cfg   i_cfg,
    output logic   o_emit,
    output t_job   o_job
);
    localparam int WIN = 2 * HALF_WINDOW + 1;

    logic signed [19:0] r_wx [WIN];
    logic signed [19:0] r_wy [WIN];
    logic signed [19:0] r_wz [WIN];
    logic [7:0]         r_wi [WIN];
    logic [15:0]        r_pos;
    logic [7:0]         r_ring;

    logic signed [19:0] sx [WIN];
    logic signed [19:0] sy [WIN];
    logic signed [19:0] sz [WIN];
    logic [7:0]         si [WIN];
    logic [15:0] pos_eff;
    logic [7:0]  ring_eff;
    logic        active;
    logic signed [DIFF_BITS-1:0] sumx, sumy, sumz;
    logic [16:0] pos_nxt;

    // window as it stands after this point shifts in
    always_comb begin
        for (int k = 0; k < WIN; k++) begin
            if (k < WIN - 1) begin
                sx[k] = r_wx[k+1]; sy[k] = r_wy[k+1]; sz[k] = r_wz[k+1]; si[k] = r_wi[k+1];
            end else begin
                sx[k] = i_pt.pos_x; sy[k] = i_pt.pos_y; sz[k] = i_pt.pos_z;
                si[k] = i_pt.reflectivity;
            end
        end
    end

    always_comb begin
        sumx = '0; sumy = '0; sumz = '0;
        for (int k = 0; k < WIN; k++) begin
            if (k != HALF_WINDOW) begin
                sumx = sumx + DIFF_BITS'(sx[k]);
                sumy = sumy + DIFF_BITS'(sy[k]);
                sumz = sumz + DIFF_BITS'(sz[k]);
            end
        end
    end

    assign pos_eff  = i_pt.scan_start ? '0 : r_pos;
    assign ring_eff = i_pt.scan_start ? '0 : r_ring;
    assign active   = ring_eff < i_cfg.ring_count;
    assign pos_nxt  = {1'b0, pos_eff} + 17'd1;
    assign o_emit   = i_take && active && (pos_eff >= 16'(2 * HALF_WINDOW));

    always_comb begin
        o_job.cx      = sx[HALF_WINDOW];
        o_job.cy      = sy[HALF_WINDOW];
        o_job.cz      = sz[HALF_WINDOW];
        o_job.refl    = si[HALF_WINDOW];
        o_job.ring    = ring_eff[6:0];
        o_job.dx      = DIFF_BITS'(2 * HALF_WINDOW) * DIFF_BITS'(sx[HALF_WINDOW]) - sumx;
        o_job.dy      = DIFF_BITS'(2 * HALF_WINDOW) * DIFF_BITS'(sy[HALF_WINDOW]) - sumy;
        o_job.dz      = DIFF_BITS'(2 * HALF_WINDOW) * DIFF_BITS'(sz[HALF_WINDOW]) - sumz;
        o_job.grad_in = (si[HALF_WINDOW+1] > si[HALF_WINDOW-1])
                      ? si[HALF_WINDOW+1] - si[HALF_WINDOW-1]
                      : si[HALF_WINDOW-1] - si[HALF_WINDOW+1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_ring <= '0;
            for (int k = 0; k < WIN; k++) begin
                r_wx[k] <= '0; r_wy[k] <= '0; r_wz[k] <= '0; r_wi[k] <= '0;
            end
        end else if (i_take) begin
            r_pos  <= pos_eff;
            r_ring <= ring_eff;
            if (active) begin
                for (int k = 0; k < WIN; k++) begin
                    r_wx[k] <= sx[k]; r_wy[k] <= sy[k]; r_wz[k] <= sz[k]; r_wi[k] <= si[k];
                end
                if (pos_nxt >= {1'b0, i_cfg.points_per_ring}) begin
                    r_pos <= '0;
                    if (ring_eff != 8'hFF) r_ring <= ring_eff + 8'd1;
                end else begin
                    r_pos <= pos_nxt[15:0];
                end
            end
        end
    end
endmodule

// ----- hw/rtl/lrfc_queue.sv -----
// lrfc_queue: four-entry job queue between front and back.
// Depends on lrfc_pkg.
module lrfc_queue import lrfc_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_wr,
    input  t_job i_data,
    input  logic i_rd,
    output logic o_full,
    output logic o_nonempty,
    output t_job o_data
);
    t_job       r_mem [4];
    logic [1:0] r_wp, r_rp;
    logic [2:0] r_cnt;

    assign o_full     = r_cnt == 3'd4;
    assign o_nonempty = r_cnt != 3'd0;
    assign o_data     = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_wr) r_mem[r_wp] <= i_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0;
        end else begin
            if (i_wr) r_wp <= r_wp + 2'd1;
            if (i_rd) r_rp <= r_rp + 2'd1;
            r_cnt <= r_cnt + 3'(i_wr) - 3'(i_rd);
        end
    end
endmodule

// ----- hw/rtl/lrfc_back.sv -----
// lrfc_back: sequenced squares, shared restoring divider, bit-pair isqrt, classify.
// Depends on lrfc_pkg.
module lrfc_back import lrfc_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_job_vld,
    input  t_job    i_job,
    input  t_cfg    i_cfg,
    input  logic    i_pop,
    output logic    o_job_rd,
    output logic    o_vld,
    output t_result o_res
);
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SQ   = 3'd1;
    localparam logic [2:0] ST_PREP = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_SQRT = 3'd4;
    localparam logic [2:0] ST_DONE = 3'd5;

    logic [2:0]          r_st;
    logic [4:0]          r_cnt;
    logic                r_grad_ph;
    t_job                r_job;
    logic [NUM_BITS-1:0] r_num;
    logic [DEN_BITS-1:0] r_den;
    logic [NUM_BITS-1:0] r_rem;
    logic [63:0]         r_ds;
    logic [23:0]         r_q;
    logic                r_sat;
    logic [23:0]         r_smooth, r_grad;
    logic [DEN_BITS-1:0] r_sv, r_sr, r_sb;
    logic                r_vld;
    t_result             r_res;
    logic                r_div_end;

    logic signed [DIFF_BITS-1:0] op;
    logic [DIFF_BITS-1:0]        op_abs;
    logic [2*DIFF_BITS-1:0]      sq;
    logic [DEN_BITS-1:0]         dvs;
    logic [NUM_BITS-1:0]         dvd;
    logic [DEN_BITS-1:0]         strial;
    logic [23:0]                 qv;
    logic [1:0]                  cls;

    always_comb begin
        case (r_cnt[2:0])
            3'd0:    op = r_job.dx;
            3'd1:    op = r_job.dy;
            3'd2:    op = r_job.dz;
            3'd3:    op = DIFF_BITS'(r_job.cx);
            3'd4:    op = DIFF_BITS'(r_job.cy);
            default: op = DIFF_BITS'(r_job.cz);
        endcase
    end
    assign op_abs = op[DIFF_BITS-1] ? DIFF_BITS'(-op) : op;
    assign sq     = op_abs * op_abs;

    // divisor and dividend of whichever division is being set up
    assign dvs = r_grad_ph ? r_sr + DEN_BITS'(1) : r_den + DEN_BITS'(1);
    assign dvd = r_grad_ph ? r_num : {r_num[NUM_BITS-9:0], 8'd0};
    assign strial = r_sr + r_sb;
    assign qv  = r_sat ? SAT24 : r_q;

    always_comb begin
        if (r_smooth > i_cfg.edge_limit)            cls = PC_EDGE;
        else if (r_smooth < i_cfg.flat_limit)       cls = PC_PLANAR;
        else if (i_cfg.intensity_enable && r_grad > i_cfg.gradient_min
                 && r_grad < i_cfg.gradient_max)    cls = PC_INTENSITY;
        else                                        cls = PC_NONE;
    end

    assign o_job_rd = (r_st == ST_IDLE) && i_job_vld;
    assign o_vld    = r_vld;
    assign o_res    = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st  <= ST_IDLE;
            r_vld <= 1'b0;
            r_cnt <= '0;
            r_grad_ph <= 1'b0;
        end else begin
            if (i_pop && r_vld) r_vld <= 1'b0;
            unique case (r_st)
                ST_IDLE: begin
                    if (i_job_vld) begin
                        r_job <= i_job;
                        r_num <= '0;
                        r_den <= '0;
                        r_cnt <= '0;
                        r_grad_ph <= 1'b0;
                        r_grad <= '0;
                        r_st  <= ST_SQ;
                    end
                end
                ST_SQ: begin
                    if (r_cnt < 5'd3) r_num <= r_num + NUM_BITS'(sq);
                    else              r_den <= r_den + DEN_BITS'(sq);
                    r_cnt <= r_cnt + 5'd1;
                    if (r_cnt == 5'd5) r_st <= ST_PREP;
                end
                ST_PREP: begin
                    r_sat <= {4'd0, dvd} >= {dvs, 24'd0};
                    r_rem <= dvd;
                    r_ds  <= {dvs[40:0], 23'd0};
                    r_q   <= '0;
                    r_cnt <= '0;
                    r_st  <= ST_DIV;
                end
                ST_DIV: begin
                    if ({2'd0, r_rem} >= r_ds) begin
                        r_rem <= r_rem - r_ds[NUM_BITS-1:0];
                        r_q   <= {r_q[22:0], 1'b1};
                    end else begin
                        r_q   <= {r_q[22:0], 1'b0};
                    end
                    r_ds  <= r_ds >> 1;
                    r_cnt <= r_cnt + 5'd1;
                    if (r_cnt == 5'd23) begin
                        r_cnt <= '0;
                        r_st  <= ST_DONE;
                        if (!r_grad_ph && i_cfg.intensity_enable) begin
                            r_st <= ST_SQRT;
                            r_sv <= r_den;
                            r_sr <= '0;
                            r_sb <= DEN_BITS'(1) << 40;
                            r_num <= NUM_BITS'(26'(r_job.grad_in) * 26'(GRAD_SCALE));
                        end
                    end
                end
                ST_SQRT: begin
                    if (r_sv >= strial) begin
                        r_sv <= r_sv - strial;
                        r_sr <= (r_sr >> 1) + r_sb;
                    end else begin
                        r_sr <= r_sr >> 1;
                    end
                    r_sb  <= r_sb >> 2;
                    r_cnt <= r_cnt + 5'd1;
                    if (r_cnt == 5'd20) begin
                        r_grad_ph <= 1'b1;
                        r_st <= ST_PREP;
                    end
                end
                ST_DONE: begin
                    // wait for the last quotient to be captured
                    if (!r_div_end && (!r_vld || i_pop)) begin
                        r_vld <= 1'b1;
                        r_res.out_x <= r_job.cx;
                        r_res.out_y <= r_job.cy;
                        r_res.out_z <= r_job.cz;
                        r_res.out_reflectivity <= r_job.refl;
                        r_res.ring_index <= r_job.ring;
                        r_res.point_class <= cls;
                        r_res.smoothness_value <= r_smooth;
                        r_res.gradient_value <= r_grad;
                        r_st <= ST_IDLE;
                    end
                end
                default: r_st <= ST_IDLE;
            endcase
            // quotient capture in the cycle after the divider finishes
            if (r_div_end) begin
                if (r_grad_ph) r_grad <= qv;
                else           r_smooth <= qv;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div_end <= 1'b0;
        end else begin
            r_div_end <= (r_st == ST_DIV) && (r_cnt == 5'd23);
        end
    end
endmodule

// ----- hw/rtl/lidar_ring_feature_classifier.sv -----
// lidar_ring_feature_classifier: top level, config registers, front/queue/back.
// Depends on lrfc_pkg, lrfc_front, lrfc_queue, lrfc_back.
//
//  channel   handshake              payload
//  points    i_push / o_full        i_in  (t_point)
//  results   o_empty / i_pop        o_res (t_result)
//  config    i_cfg_we               i_cfg_addr, i_cfg_data
//
// Cycles: the front takes a point per cycle while the four-entry queue has room.
// Each centre point passes through the back in order: a load, the squares of the
// three differences and coordinates, a setup and the smoothness divide steps,
// plus the isqrt steps, a setup and the gradient divide steps when intensity is
// enabled, then the output register (the quotient is captured first); only then
// is the next job taken. Ring-start points and rings past the count emit nothing.
// Reset is synchronous, active low; the config registers return to their defaults.
// A full queue stalls the input; an untaken result stalls the back, then the input once the queue fills.
module lidar_ring_feature_classifier import lrfc_pkg::*; #(
    parameter int HALF_WINDOW = HALF_WINDOW_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_push,
    output logic                     o_full,
    input  t_point                   i_in,
    output logic                     o_empty,
    input  logic                     i_pop,
    output t_result                  o_res,
    input  logic                     i_cfg_we,
    input  logic [CFG_ADDR_BITS-1:0] i_cfg_addr,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data
);
    t_cfg r_cfg;
    logic take, emit, q_full, q_ne, q_rd, out_vld;
    t_job job_in, job_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.edge_limit       <= 24'd256;
            r_cfg.flat_limit       <= 24'd26;
            r_cfg.gradient_min     <= 24'd0;
            r_cfg.gradient_max     <= SAT24;
            r_cfg.points_per_ring  <= 16'd1800;
            r_cfg.ring_count       <= 8'd16;
            r_cfg.intensity_enable <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                REG_EDGE_THR:   r_cfg.edge_limit       <= i_cfg_data;
                REG_PLANAR_THR: r_cfg.flat_limit       <= i_cfg_data;
                REG_GRAD_MIN:   r_cfg.gradient_min     <= i_cfg_data;
                REG_GRAD_MAX:   r_cfg.gradient_max     <= i_cfg_data;
                REG_PPR:        r_cfg.points_per_ring  <= i_cfg_data[15:0];
                REG_RING_CNT:   r_cfg.ring_count       <= i_cfg_data[7:0];
                REG_INT_EN:     r_cfg.intensity_enable <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // hold off input during reset so nothing is taken then
    assign o_full  = q_full || !i_rst_n;
    assign take    = i_push && !o_full;
    assign o_empty = !out_vld;

    lrfc_front #(.HALF_WINDOW(HALF_WINDOW)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_take(take), .i_pt(i_in),
        .i_cfg(r_cfg), .o_emit(emit), .o_job(job_in)
    );

    lrfc_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_wr(emit), .i_data(job_in),
        .i_rd(q_rd), .o_full(q_full), .o_nonempty(q_ne), .o_data(job_out)
    );

    lrfc_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_job_vld(q_ne), .i_job(job_out),
        .i_cfg(r_cfg), .i_pop(i_pop), .o_job_rd(q_rd), .o_vld(out_vld), .o_res(o_res)
    );
endmodule

// ----- hw/rtl/lrfc_checker.sv -----
// lrfc_checker: port-level assertions for the classifier, bound to the top level.
// Depends on lrfc_pkg.
module lrfc_checker import lrfc_pkg::*; (
    input logic    i_clk,
    input logic    i_rst_n,
    input logic    o_empty,
    input logic    i_pop,
    input t_result o_res
);
    a_empty_after_reset: assert property (@(posedge i_clk) !i_rst_n |=> o_empty)
        else $error("result shown right after reset");

    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && !i_pop) |=> (!o_empty && $stable(o_res)))
        else $error("waiting result changed or vanished");

    a_intensity_grad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && o_res.point_class == PC_INTENSITY) |-> o_res.gradient_value != 24'd0)
        else $error("intensity class with zero gradient");
endmodule

bind lidar_ring_feature_classifier lrfc_checker u_lrfc_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .o_empty(o_empty), .i_pop(i_pop), .o_res(o_res)
);
